// ===== rtl/core/lbks_pkg.sv =====
`default_nettype none
package lbks_pkg;

  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic               kind_t;

  // transaction kinds on the input channel
  localparam kind_t KIND_LOAD  = 1'b0;
  localparam kind_t KIND_QUERY = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/lbks_if.sv =====
`default_nettype none
interface lbks_in_if;
  logic                 valid;
  logic                 ready;
  lbks_pkg::kind_t      kind;
  lbks_pkg::slot_t      slot;
  lbks_pkg::key_t       search_key;

  modport source (output valid, output kind, output slot, output search_key, input ready);
  modport sink   (input valid, input kind, input slot, input search_key, output ready);
endinterface

interface lbks_out_if;
  logic                 valid;
  logic                 ready;
  lbks_pkg::slot_t      found_slot;
  logic                 hit;

  modport source (output valid, output found_slot, output hit, input ready);
  modport sink   (input valid, input found_slot, input hit, output ready);
endinterface

interface lbks_cfg_if;
  logic                 valid;
  logic                 ready;
  lbks_pkg::count_t     entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lbks_key_ram.sv =====
`default_nettype none
module lbks_key_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire lbks_pkg::key_t       wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output lbks_pkg::key_t            rd_data
);
  import lbks_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lower_bound_key_search.sv =====
`default_nettype none
// lower-bound search over a table of sorted 64-bit keys
//
// in_ch: a load transaction (kind = load) writes search_key into the table at
//   slot and gives no result; slots at or above TABLE_DEPTH are dropped.
//   a query transaction (kind = query) searches entries 0 .. entry_count-1 and
//   gives one result on out_ch: the first slot whose key is >= search_key
//   (entry_count-1 if none), and hit when the key there equals search_key.
// cfg_ch: writes entry_count (0 acts as 1, values above TABLE_DEPTH act as
//   TABLE_DEPTH); cfg_ch is always ready. the user must write it only while
//   idle: the block itself does not enforce this.
// timing: a load is written to the key ram as it is taken and leaves the
//   controller idle. a query runs halving steps, each waiting on one read of
//   the key ram at the window midpoint, then a final step that reads the
//   chosen slot and does the hit check before the result register is written.
// one query is in flight at a time; the next transaction is taken once the
//   result sits in the output register, even while out_ch is stalled. a stalled
//   out_ch holds a second finished query in its final step.
// reset: clears control state and sets entry_count to 1; the key table is
//   not cleared and holds unknown data until loaded.
module lower_bound_key_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lbks_in_if.sink     in_ch,
  lbks_out_if.source  out_ch,
  lbks_cfg_if.sink    cfg_ch
);
  import lbks_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINAL  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  key_t          key_r;
  count_t        count_r;
  logic          out_valid_r;
  slot_t         found_r;
  logic          hit_r;

  logic [CW-1:0] eff_cnt;
  logic [AW-1:0] hi_init;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] rd_addr;
  key_t          rd_data;
  logic          in_fire;
  logic          is_query;
  logic          ram_wr_en;
  logic          out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_query = (in_ch.kind == KIND_QUERY);
  assign out_free = !out_valid_r || out_ch.ready;

  // clamp the programmed count into 1 .. TABLE_DEPTH
  always_comb begin
    eff_cnt = CW'(count_r);
    if (eff_cnt == '0) begin
      eff_cnt = CW'(1);
    end
    if (eff_cnt > CW'(TABLE_DEPTH)) begin
      eff_cnt = CW'(TABLE_DEPTH);
    end
  end
  assign hi_init = AW'(eff_cnt - CW'(1));

  // next search window, then the address of the next ram read:
  // the next midpoint while the window is open, else the final slot
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        lo_nxt = '0;
        hi_nxt = hi_init;
        if (in_fire && is_query) begin
          state_nxt = (hi_init != '0) ? ST_SEARCH : ST_FINAL;
        end
      end
      ST_SEARCH: begin
        if (key_r <= rd_data) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + AW'(1);
        end
        state_nxt = (lo_nxt < hi_nxt) ? ST_SEARCH : ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt = mid_sum[AW:1];
    rd_addr = (lo_nxt < hi_nxt) ? mid_nxt : lo_nxt;
  end

  // loads are only taken while idle, so they never race a search read
  assign ram_wr_en = in_fire && !is_query && (32'(in_ch.slot) < 32'(TABLE_DEPTH));

  lbks_key_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (AW'(in_ch.slot)),
    .wr_data (in_ch.search_key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= count_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_r <= cfg_ch.entry_count;
      end
      if (state_r == ST_FINAL && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search window and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && is_query) begin
      key_r <= in_ch.search_key;
    end
    if (state_r == ST_IDLE || state_r == ST_SEARCH) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
    // rd_data here is the key at lo_r, read back as the final step
    if (state_r == ST_FINAL && out_free) begin
      found_r <= SLOT_W'(lo_r);
      hit_r   <= (rd_data == key_r);
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.found_slot = found_r;
  assign out_ch.hit        = hit_r;

endmodule
`default_nettype wire
